// File: src/pipe_water_hammer_stencil_top_defines.svh
// Assertion macros for the water hammer stencil block
`ifndef PIPE_WATER_HAMMER_STENCIL_TOP_DEFINES_SVH
`define PIPE_WATER_HAMMER_STENCIL_TOP_DEFINES_SVH

// same-cycle implication
`define PWHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PWHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/pwhs_pkg.sv
// ----------------------------------------------------------------------------
// pwhs_pkg
// Shared constants and types of the water hammer stencil block.
// ----------------------------------------------------------------------------
package pwhs_pkg;

  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int QUEUE_DEPTH    = 2;

  // end rules; code three behaves as reflective
  localparam logic [1:0] MODE_REFLECT  = 2'd0;
  localparam logic [1:0] MODE_PRESSURE = 2'd1;
  localparam logic [1:0] MODE_FLOW     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_VAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_VAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P2Q_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Q2P_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRIC_GAIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_STEP  = 3'd7;

  // what the back end does with one command
  typedef struct packed {
    logic compute;  // run the interior update
    logic do_l;     // emit left end cell
    logic chain;    // left end result becomes base (two-cell segment)
    logic do_m;     // emit base cell
    logic do_r;     // emit right end cell
    logic m_last;   // base cell closes the segment
  } cmd_ctl_t;

endpackage

// File: src/pwhs_queue.sv
// ----------------------------------------------------------------------------
// pwhs_queue
// Small FIFO of commands between the front and back ends.
// ----------------------------------------------------------------------------
module pwhs_queue import pwhs_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data,
  output logic [1:0]       count
);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;

  assign full     = (count == 2'(QUEUE_DEPTH));
  assign valid    = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: src/pwhs_front.sv
// ----------------------------------------------------------------------------
// pwhs_front
// Takes cells, keeps the three-cell window and issues back end commands.
// ----------------------------------------------------------------------------
module pwhs_front import pwhs_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_q,
  input  logic signed [DATA_WIDTH-1:0] in_p,
  input  logic                        in_last,
  input  logic                        q_full,
  output logic                        push,
  output logic [$bits(cmd_ctl_t)+6*DATA_WIDTH-1:0] push_data
);

  logic [1:0]                  pos;
  logic signed [DATA_WIDTH-1:0] first_q, first_p, older_q, older_p, newer_q, newer_p;
  logic                        acc;
  cmd_ctl_t                    ctl;

  assign in_ready = ~q_full;
  assign acc      = in_valid & in_ready;

  always_comb begin
    ctl  = '0;
    push = 1'b0;
    unique case (pos)
      2'd0: begin
        push = acc & in_last;
        ctl  = '{compute: 1'b0, do_l: 1'b0, chain: 1'b0, do_m: 1'b1, do_r: 1'b0, m_last: 1'b1};
      end
      2'd1: begin
        push = acc & in_last;
        ctl  = '{compute: 1'b0, do_l: 1'b1, chain: 1'b1, do_m: 1'b0, do_r: 1'b1, m_last: 1'b0};
      end
      default: begin
        push = acc;
        ctl  = '{compute: 1'b1, do_l: (pos == 2'd2), chain: 1'b0, do_m: 1'b1,
                 do_r: in_last, m_last: 1'b0};
      end
    endcase
  end

  // order from low bits: ql, pl, qc, pc, qr, pr, ctl
  always_comb begin
    if (pos[1]) begin
      push_data = {ctl, in_p, in_q, newer_p, newer_q, older_p, older_q};
    end else begin
      push_data = {ctl, in_p, in_q, in_p, in_q, in_p, in_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 2'd0;
    end else if (acc) begin
      unique case (pos)
        2'd0: begin
          if (!in_last) pos <= 2'd1;
        end
        2'd1: pos <= in_last ? 2'd0 : 2'd2;
        default: pos <= in_last ? 2'd0 : 2'd3;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (pos == 2'd0) begin
        first_q <= in_q;
        first_p <= in_p;
      end else if (pos == 2'd1) begin
        older_q <= first_q;
        older_p <= first_p;
        newer_q <= in_q;
        newer_p <= in_p;
      end else begin
        older_q <= newer_q;
        older_p <= newer_p;
        newer_q <= in_q;
        newer_p <= in_p;
      end
    end
  end

endmodule

// File: src/pwhs_back.sv
// ----------------------------------------------------------------------------
// pwhs_back
// Runs the interior update on one shared multiplier and emits end cells.
// ----------------------------------------------------------------------------
module pwhs_back import pwhs_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  logic [$bits(cmd_ctl_t)+6*DATA_WIDTH-1:0] q_data,
  output logic                         pop,
  input  logic [1:0]                   left_mode,
  input  logic [1:0]                   right_mode,
  input  logic signed [DATA_WIDTH-1:0] left_val,
  input  logic signed [DATA_WIDTH-1:0] right_val,
  input  logic signed [DATA_WIDTH-1:0] p2q_gain,
  input  logic signed [DATA_WIDTH-1:0] q2p_gain,
  input  logic signed [DATA_WIDTH-1:0] fric_gain,
  input  logic signed [DATA_WIDTH-1:0] grav_step,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_q,
  output logic signed [DATA_WIDTH-1:0] out_p,
  output logic                         out_last,
  output logic                         out_sat
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int AW = 2 * W + 3;

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_LEFT, ST_MID, ST_RIGHT} state_t;

  typedef struct packed {
    logic signed [W-1:0] q;
    logic signed [W-1:0] p;
    logic                f;
  } cell_t;

  function automatic cell_t sat_w(input logic signed [AW-1:0] x);
    cell_t r;
    r = '0;
    if (x > AW'($signed({1'b0, {(W-1){1'b1}}}))) begin
      r.q = {1'b0, {(W-1){1'b1}}};
      r.f = 1'b1;
    end else if (x < AW'($signed({1'b1, {(W-1){1'b0}}}))) begin
      r.q = {1'b1, {(W-1){1'b0}}};
      r.f = 1'b1;
    end else begin
      r.q = x[W-1:0];
    end
    return r;
  endfunction

  function automatic cell_t end_cell(input logic [1:0] mode, input logic signed [W-1:0] v,
                                     input cell_t n);
    cell_t r;
    cell_t s;
    r = n;
    s = sat_w(-AW'(n.q));
    priority case (mode)
      MODE_PRESSURE: r.p = v;
      MODE_FLOW:     r.q = v;
      default: begin
        r.q = s.q;
        r.f = n.f | s.f;
      end
    endcase
    return r;
  endfunction

  state_t              state;
  logic [2:0]          step;
  cmd_ctl_t            ctl;
  logic signed [W-1:0] ql, pl, qc, pc, qr, pr;
  logic signed [PW-1:0] prod;
  logic signed [W-1:0] fsq;
  logic                fsq_f;
  logic signed [PW:0]  acc1, acc2;
  logic signed [PW-1:0] fric;
  cell_t               base;

  cmd_ctl_t            in_ctl;
  logic signed [W-1:0] opa, opb;
  logic signed [PW-1:0] sq;
  cell_t               s_sat, fq, fp, e_l, e_r;
  logic                slot_free;
  logic                emit;
  state_t              start_state, after_l, after_m;

  assign in_ctl    = q_data[6*W +: $bits(cmd_ctl_t)];
  assign pop       = (state == ST_IDLE) && q_valid;
  assign slot_free = ~out_valid | out_ready;
  // a result is loaded into the output register this cycle
  assign emit      = slot_free && (state == ST_LEFT || state == ST_MID || state == ST_RIGHT);

  always_comb begin
    unique case (step)
      3'd0: begin opa = qc; opb = qc; end
      3'd1: begin opa = p2q_gain; opb = pl; end
      3'd2: begin opa = fric_gain; opb = fsq; end
      3'd3: begin opa = p2q_gain; opb = pr; end
      3'd4: begin opa = q2p_gain; opb = qr; end
      default: begin opa = q2p_gain; opb = ql; end
    endcase
  end

  always_comb begin
    sq    = qc[W-1] ? -prod : prod;
    s_sat = sat_w(AW'(sq) >>> FRAC_BITS);
    fq    = sat_w(AW'(qc) + (AW'(acc1) >>> FRAC_BITS) - (AW'(fric) >>> FRAC_BITS)
                  + AW'(grav_step));
    fp    = sat_w(AW'(pc) - (AW'(acc2) >>> FRAC_BITS));
    e_l   = end_cell(left_mode, left_val, base);
    e_r   = end_cell(right_mode, right_val, base);
    start_state = ctl.do_l ? ST_LEFT : (ctl.do_m ? ST_MID : ST_RIGHT);
    after_l     = ctl.do_m ? ST_MID : (ctl.do_r ? ST_RIGHT : ST_IDLE);
    after_m     = ctl.do_r ? ST_RIGHT : ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ctl <= in_ctl;
      ql  <= q_data[0 +: W];
      pl  <= q_data[W +: W];
      qc  <= q_data[2*W +: W];
      pc  <= q_data[3*W +: W];
      qr  <= q_data[4*W +: W];
      pr  <= q_data[5*W +: W];
    end
    if (state == ST_MUL) begin
      prod <= opa * opb;
      unique case (step)
        3'd1: begin fsq <= s_sat.q; fsq_f <= s_sat.f; end
        3'd2: acc1 <= (PW+1)'(prod);
        3'd3: fric <= prod;
        3'd4: acc1 <= acc1 - (PW+1)'(prod);
        3'd5: acc2 <= (PW+1)'(prod);
        3'd6: acc2 <= acc2 - (PW+1)'(prod);
        default: ;
      endcase
    end
    if (out_ready || !out_valid) begin
      unique case (state)
        ST_LEFT:  begin out_q <= e_l.q; out_p <= e_l.p; out_sat <= e_l.f; out_last <= 1'b0; end
        ST_MID:   begin out_q <= base.q; out_p <= base.p; out_sat <= base.f;
                        out_last <= ctl.m_last; end
        ST_RIGHT: begin out_q <= e_r.q; out_p <= e_r.p; out_sat <= e_r.f; out_last <= 1'b1; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            step <= 3'd0;
            if (in_ctl.compute) begin
              state <= ST_MUL;
            end else begin
              base  <= '{q: q_data[2*W +: W], p: q_data[3*W +: W], f: 1'b0};
              state <= in_ctl.do_l ? ST_LEFT : ST_MID;
            end
          end
        end
        ST_MUL: begin
          step <= step + 3'd1;
          if (step == 3'd7) begin
            base  <= '{q: fq.q, p: fp.q, f: fsq_f | fq.f | fp.f};
            state <= start_state;
          end
        end
        ST_LEFT: begin
          if (slot_free) begin
            if (ctl.chain) base <= e_l;
            state <= after_l;
          end
        end
        ST_MID: begin
          if (slot_free) begin
            state <= after_m;
          end
        end
        ST_RIGHT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/pipe_water_hammer_stencil_top.sv
// ----------------------------------------------------------------------------
// pipe_water_hammer_stencil_top
// One explicit water hammer time step over a stream of pipe cells.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)            | tlast          | tuser
//  s_*     | in  | cell_flow, cell_pressure      | cell_is_last   | -
//  m_*     | out | next_flow, next_pressure      | result_is_last | saturated
//  cfg_*   | in  | write enable, index, data     | -              | -
//
// Each command is issued from the idle state; an interior cell then occupies the
// multiplier sequencer, then its results are emitted one by one, each waiting
// for the output register; end-only commands skip the sequencer.
// The front takes cells while the two-entry command queue has room.
// rst is synchronous; config regs reset to zero. The output register
// holds a result until m_tready; the back end waits for it meanwhile.
`include "pipe_water_hammer_stencil_top_defines.svh"

module pipe_water_hammer_stencil_top import pwhs_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,  // cell_flow, cell_pressure
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_tdata,  // next_flow, next_pressure
  output logic                        m_tlast,
  output logic                        m_tuser,          // saturated
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_addr,
  input  logic [DATA_WIDTH-1:0]       cfg_wdata
);

  localparam int TDW = ((2*DATA_WIDTH+7)/8)*8;
  localparam int QW  = $bits(cmd_ctl_t) + 6*DATA_WIDTH;

  logic [1:0]            left_mode, right_mode;
  logic signed [DATA_WIDTH-1:0] left_val, right_val, p2q_gain, q2p_gain, fric_gain, grav_step;
  logic                  push, full, pop, qvalid;
  logic [QW-1:0]         push_data, pop_data;
  logic [1:0]            qcount;
  logic signed [DATA_WIDTH-1:0] out_q, out_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_mode <= '0; right_mode <= '0; left_val <= '0; right_val <= '0;
      p2q_gain <= '0; q2p_gain <= '0; fric_gain <= '0; grav_step <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LEFT_MODE:  left_mode  <= cfg_wdata[1:0];
        REG_RIGHT_MODE: right_mode <= cfg_wdata[1:0];
        REG_LEFT_VAL:   left_val   <= cfg_wdata;
        REG_RIGHT_VAL:  right_val  <= cfg_wdata;
        REG_P2Q_GAIN:   p2q_gain   <= cfg_wdata;
        REG_Q2P_GAIN:   q2p_gain   <= cfg_wdata;
        REG_FRIC_GAIN:  fric_gain  <= cfg_wdata;
        REG_GRAV_STEP:  grav_step  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pwhs_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_q(s_tdata[DATA_WIDTH-1:0]), .in_p(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .in_last(s_tlast), .q_full(full), .push(push), .push_data(push_data)
  );

  pwhs_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .valid(qvalid), .pop_data(pop_data), .count(qcount)
  );

  pwhs_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(qvalid), .q_data(pop_data), .pop(pop),
    .left_mode(left_mode), .right_mode(right_mode),
    .left_val(left_val), .right_val(right_val),
    .p2q_gain(p2q_gain), .q2p_gain(q2p_gain),
    .fric_gain(fric_gain), .grav_step(grav_step),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_q(out_q), .out_p(out_p), .out_last(m_tlast), .out_sat(m_tuser)
  );

  assign m_tdata = TDW'({out_p, out_q});

  `PWHS_ASSERT_NOW(a_no_push_full, push, !full, "command pushed into full queue")
  `PWHS_ASSERT_NOW(a_count_range, 1'b1, qcount <= 2'(QUEUE_DEPTH), "queue count overflow")
  `PWHS_ASSERT_NEXT(a_pop_drains, pop && !push && qcount == 2'd1, !qvalid,
                    "queue not empty after last pop")

endmodule
